/* rtl/core/cprs_pkg.sv */
// cprs_pkg: shared widths, codes, state type, divider structs and helpers
// for the convex polygon row span unit; no dependencies
package cprs_pkg;

  localparam int CW   = 24;  // coordinate width
  localparam int RW   = 25;  // origin-relative coordinate width
  localparam int DW   = 26;  // coordinate difference width
  localparam int TW   = 28;  // row band bound width
  localparam int PW   = DW + TW;
  localparam int QW   = 27;  // clipped x offset width
  localparam int COLW = 28;  // column width before saturation

  localparam int MAX_VERTICES_DEF = 16;
  localparam int MAX_ROWS_DEF     = 64;

  localparam logic [1:0] CFG_ORIGIN_X   = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Y   = 2'd1;
  localparam logic [1:0] CFG_CELL_SHIFT = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FEW  = 2'd1;
  localparam logic [1:0] ST_FLAT = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_ROW, S_EDGE_CHK, S_EDGE_RD, S_EDGE_TEST, S_COL,
    S_MUL, S_DIV_GO, S_DIV_WAIT, S_ACC, S_CHAIN_END, S_FIN_ROW, S_OUT
  } seq_state_t;

  typedef struct packed {
    logic                 start;
    logic signed [PW-1:0] num;
    logic        [DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [PW-1:0] quo;
  } div_rsp_t;

  function automatic logic signed [RW-1:0] rel(input logic signed [CW-1:0] v,
                                               input logic signed [CW-1:0] o);
    return RW'(v) - RW'(o);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [COLW-1:0] v);
    if (v < -32768) return 16'sh8000;
    if (v > 32767) return 16'sh7fff;
    return v[15:0];
  endfunction

endpackage

/* rtl/core/cprs_if.sv */
// cprs_if: valid/ready channel interfaces for vertex input and span output
// depends on nothing
interface cprs_in_if;
  logic              valid;
  logic              ready;
  logic signed [23:0] vertex_x;
  logic signed [23:0] vertex_y;
  logic              last_vertex;
  modport source(output valid, vertex_x, vertex_y, last_vertex, input ready);
  modport sink(input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface cprs_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] row_index;
  logic signed [15:0] span_begin;
  logic signed [16:0] span_end;
  logic              row_last;
  logic        [1:0] status;
  modport source(output valid, row_index, span_begin, span_end, row_last, status,
                 input ready);
  modport sink(input valid, row_index, span_begin, span_end, row_last, status,
               output ready);
endinterface

/* rtl/core/cprs_vertex_store.sv */
// cprs_vertex_store: vertex x/y memory, one write port, two registered read ports
// depends on cprs_pkg
module cprs_vertex_store #(
  parameter int DEPTH = cprs_pkg::MAX_VERTICES_DEF
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [$clog2(DEPTH)-1:0]          waddr,
  input  logic signed [cprs_pkg::CW-1:0]    wx,
  input  logic signed [cprs_pkg::CW-1:0]    wy,
  input  logic [$clog2(DEPTH)-1:0]          raddr_a,
  input  logic [$clog2(DEPTH)-1:0]          raddr_b,
  output logic signed [cprs_pkg::CW-1:0]    rd_xa,
  output logic signed [cprs_pkg::CW-1:0]    rd_ya,
  output logic signed [cprs_pkg::CW-1:0]    rd_xb,
  output logic signed [cprs_pkg::CW-1:0]    rd_yb
);

  logic signed [cprs_pkg::CW-1:0] mem_x [DEPTH];
  logic signed [cprs_pkg::CW-1:0] mem_y [DEPTH];
  logic signed [cprs_pkg::CW-1:0] xa_r, ya_r, xb_r, yb_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_x[waddr] <= wx;
      mem_y[waddr] <= wy;
    end
  end

  always_ff @(posedge clk) begin
    xa_r <= mem_x[raddr_a];
    ya_r <= mem_y[raddr_a];
    xb_r <= mem_x[raddr_b];
    yb_r <= mem_y[raddr_b];
  end

  assign rd_xa = xa_r;
  assign rd_ya = ya_r;
  assign rd_xb = xb_r;
  assign rd_yb = yb_r;

endmodule

/* rtl/core/cprs_floor_div.sv */
// cprs_floor_div: bit-serial floor division of a signed numerator by a
// positive divisor, one quotient bit per cycle; depends on cprs_pkg
module cprs_floor_div (
  input  logic               clk,
  input  logic               rst_n,
  input  cprs_pkg::div_req_t req,
  output cprs_pkg::div_rsp_t rsp
);

  localparam int PW  = cprs_pkg::PW;
  localparam int DW  = cprs_pkg::DW;
  localparam int CNW = $clog2(PW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] work_r, work_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic          neg_r, neg_nxt;
  logic [DW:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem_r, work_r[PW-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    work_nxt = work_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNW'(PW);
      neg_nxt  = req.num < 0;
      work_nxt = (req.num < 0) ? PW'(-req.num) : PW'(req.num);
      rem_nxt  = '0;
      den_nxt  = req.den;
    end else if (busy_r) begin
      rem_nxt  = ge ? DW'(rem_sh - {1'b0, den_r}) : DW'(rem_sh);
      work_nxt = {work_r[PW-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == CNW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    neg_r  <= neg_nxt;
  end

  // floor for negative numerators: one further down when inexact
  always_comb begin
    rsp.done = done_r;
    if (neg_r) rsp.quo = -$signed(work_r) - ((rem_r != '0) ? PW'(1) : PW'(0));
    else       rsp.quo = $signed(work_r);
  end

endmodule

/* rtl/core/convex_polygon_row_spans_unit.sv */
// convex_polygon_row_spans_unit: top level, sequencer over the vertex store,
// one shared multiplier and the serial floor divider
// depends on cprs_pkg, cprs_if, cprs_vertex_store, cprs_floor_div
//
// usage:
//   in_chan takes one vertex per transaction (x, y in Q16.8, last_vertex
//   closes the polygon); vertices load at one per cycle while idle.
//   after the closing vertex in_chan.ready drops and the row walk runs:
//   one out_chan transaction per grid row from the lowest to the highest
//   vertex row (at most MAX_ROWS), row_last on the final one.
//   fewer than three vertices or zero height give a single transaction
//   with the matching status.
//   per row: each chain edge visited is read and tested against the band; an
//   endpoint in the band gives its column directly, one clipped to the band
//   goes through the multiplier and the serial divider; each row then waits in
//   the output register until out_chan.ready. a stalled receiver holds the
//   span and freezes the walk. cfg_we writes origin_x, origin_y or cell_shift;
//   the user must write them while idle only, the block does not enforce it.
//   reset (rst_n low, synchronous) empties the vertex count, restores origin 0
//   and cell_shift 8; stored vertices are not cleared.
module convex_polygon_row_spans_unit #(
  parameter int MAX_VERTICES = cprs_pkg::MAX_VERTICES_DEF,
  parameter int MAX_ROWS     = cprs_pkg::MAX_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  cprs_in_if.sink     in_chan,
  cprs_out_if.source  out_chan,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  localparam int IW   = $clog2(MAX_VERTICES);
  localparam int CNTW = $clog2(MAX_VERTICES + 1);
  localparam int ROWW = $clog2(MAX_ROWS + 1);
  localparam int CW   = cprs_pkg::CW;
  localparam int RW   = cprs_pkg::RW;
  localparam int DW   = cprs_pkg::DW;
  localparam int TW   = cprs_pkg::TW;
  localparam int PW   = cprs_pkg::PW;
  localparam int QW   = cprs_pkg::QW;
  localparam int COLW = cprs_pkg::COLW;

  cprs_pkg::seq_state_t state_r, state_nxt;

  logic signed [CW-1:0]   origin_x_r, origin_y_r;
  logic [3:0]             cell_shift_r;
  logic [CNTW-1:0]        vcount_r, vcount_nxt;
  logic                   vovf_r, vovf_nxt;
  logic signed [CW-1:0]   ymin_r, ymin_nxt, ymax_r, ymax_nxt;
  logic [IW-1:0]          low_r, low_nxt, high_r, high_nxt;
  logic [IW-1:0]          lcur_r, lcur_nxt, rcur_r, rcur_nxt;
  logic [IW-1:0]          lend_r, lend_nxt, rend_r, rend_nxt;
  logic [IW-1:0]          idx_r, idx_nxt, fidx_r, fidx_nxt;
  logic                   found_r, found_nxt, side_r, side_nxt, ep_r, ep_nxt;
  logic signed [RW-1:0]   rmin_r, rmin_nxt;
  logic [ROWW-1:0]        rows_r, rows_nxt, rowi_r, rowi_nxt;
  logic [1:0]             st_r, st_nxt;
  logic signed [TW-1:0]   lo_r, lo_nxt, hi_r, hi_nxt;
  logic signed [RW-1:0]   pxa_r, pxa_nxt, pya_r, pya_nxt, pxb_r, pxb_nxt, pyb_r, pyb_nxt;
  logic signed [DW-1:0]   mula_r, mula_nxt;
  logic signed [TW-1:0]   mulb_r, mulb_nxt;
  logic signed [PW-1:0]   prod_r, prod_nxt;
  logic                   dneg_r, dneg_nxt;
  logic [DW-1:0]          dabs_r, dabs_nxt;
  logic signed [COLW-1:0] col_r, col_nxt, c1_r, c1_nxt, cmin_r, cmin_nxt, cmax_r, cmax_nxt;
  logic                   any_r, any_nxt;
  logic signed [15:0]     orow_r, orow_nxt, obeg_r, obeg_nxt;
  logic signed [16:0]     oend_r, oend_nxt;
  logic                   olast_r, olast_nxt;
  logic [1:0]             ost_r, ost_nxt;

  logic                   in_acc;
  logic [CNTW-1:0]        idx_inc;
  logic [IW-1:0]          idx_nx, idx_pv, step_idx, end_sel, low_pv, high_pv;
  logic signed [CW-1:0]   rd_xa, rd_ya, rd_xb, rd_yb;
  logic signed [RW-1:0]   rel_ymin, rel_ymax, rmin_c, rmax_c, row_r_c;
  logic [DW-1:0]          rows_full;
  logic signed [TW-1:0]   lo_c, cell_t, mn, mx;
  logic signed [RW-1:0]   xa_s, ya_s, xb_s, yb_s;
  logic signed [TW-1:0]   ya_t, t_c, dt_c;
  logic signed [DW-1:0]   d_c, dx_c;
  logic signed [COLW-1:0] xa_col, direct_col, div_sum, lo_cc, hi_cc;
  logic signed [QW-1:0]   quo_q;
  logic signed [15:0]     cmax_sat;
  cprs_pkg::div_req_t     dreq;
  cprs_pkg::div_rsp_t     drsp;

  assign in_chan.ready = state_r == cprs_pkg::S_IDLE;
  assign in_acc        = in_chan.valid && in_chan.ready;

  assign idx_inc  = CNTW'(idx_r) + 1'b1;
  assign idx_nx   = (idx_inc >= vcount_r) ? '0 : IW'(idx_inc);
  assign idx_pv   = (idx_r == '0) ? IW'(vcount_r - 1'b1) : idx_r - 1'b1;
  assign step_idx = side_r ? idx_nx : idx_pv;
  assign end_sel  = side_r ? rend_r : lend_r;
  assign low_pv   = (low_r == '0) ? IW'(vcount_r - 1'b1) : low_r - 1'b1;
  assign high_pv  = (high_r == '0) ? IW'(vcount_r - 1'b1) : high_r - 1'b1;

  cprs_vertex_store #(.DEPTH(MAX_VERTICES)) u_store (
    .clk     (clk),
    .we      (in_acc && (vcount_r < CNTW'(MAX_VERTICES))),
    .waddr   (IW'(vcount_r)),
    .wx      (in_chan.vertex_x),
    .wy      (in_chan.vertex_y),
    .raddr_a (idx_r),
    .raddr_b (idx_nx),
    .rd_xa   (rd_xa),
    .rd_ya   (rd_ya),
    .rd_xb   (rd_xb),
    .rd_yb   (rd_yb)
  );

  cprs_floor_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  assign rel_ymin  = cprs_pkg::rel(ymin_r, origin_y_r);
  assign rel_ymax  = cprs_pkg::rel(ymax_r, origin_y_r);
  assign rmin_c    = rel_ymin >>> cell_shift_r;
  assign rmax_c    = rel_ymax >>> cell_shift_r;
  assign rows_full = DW'(DW'(rmax_c) - DW'(rmin_c) + DW'(1));
  assign row_r_c   = rmin_r + RW'(rowi_r);
  assign cell_t    = TW'(1) << cell_shift_r;
  assign lo_c      = TW'(row_r_c) <<< cell_shift_r;

  assign mn = (pya_r < pyb_r) ? TW'(pya_r) : TW'(pyb_r);
  assign mx = (pya_r < pyb_r) ? TW'(pyb_r) : TW'(pya_r);

  assign xa_s = ep_r ? pxb_r : pxa_r;
  assign ya_s = ep_r ? pyb_r : pya_r;
  assign xb_s = ep_r ? pxa_r : pxb_r;
  assign yb_s = ep_r ? pya_r : pyb_r;
  assign ya_t = TW'(ya_s);
  assign t_c  = (ya_t < lo_r) ? lo_r : hi_r;
  assign dt_c = t_c - ya_t;
  assign d_c  = DW'(yb_s) - DW'(ya_s);
  assign dx_c = DW'(xb_s) - DW'(xa_s);
  assign xa_col     = COLW'(xa_s);
  assign direct_col = xa_col >>> cell_shift_r;
  assign quo_q      = drsp.quo[QW-1:0];
  assign div_sum    = xa_col + COLW'(quo_q);
  assign lo_cc      = (col_r < c1_r) ? col_r : c1_r;
  assign hi_cc      = (col_r < c1_r) ? c1_r : col_r;
  assign cmax_sat   = cprs_pkg::sat16(cmax_r);

  always_comb begin
    dreq.start = state_r == cprs_pkg::S_DIV_GO;
    dreq.num   = dneg_r ? -prod_r : prod_r;
    dreq.den   = dabs_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cprs_pkg::S_IDLE:
        if (in_acc && in_chan.last_vertex) state_nxt = cprs_pkg::S_START;
      cprs_pkg::S_START: begin
        if (vcount_r < CNTW'(3) || ymax_r <= ymin_r) state_nxt = cprs_pkg::S_OUT;
        else state_nxt = cprs_pkg::S_ROW;
      end
      cprs_pkg::S_ROW: state_nxt = cprs_pkg::S_EDGE_CHK;
      cprs_pkg::S_EDGE_CHK:
        state_nxt = (idx_r == end_sel) ? cprs_pkg::S_CHAIN_END : cprs_pkg::S_EDGE_RD;
      cprs_pkg::S_EDGE_RD: state_nxt = cprs_pkg::S_EDGE_TEST;
      cprs_pkg::S_EDGE_TEST: begin
        priority if (mn > hi_r) state_nxt = cprs_pkg::S_CHAIN_END;
        else if (mx < lo_r)     state_nxt = cprs_pkg::S_EDGE_CHK;
        else                    state_nxt = cprs_pkg::S_COL;
      end
      cprs_pkg::S_COL: begin
        if ((ya_t < lo_r || ya_t > hi_r) && d_c != '0) state_nxt = cprs_pkg::S_MUL;
        else state_nxt = cprs_pkg::S_ACC;
      end
      cprs_pkg::S_MUL:      state_nxt = cprs_pkg::S_DIV_GO;
      cprs_pkg::S_DIV_GO:   state_nxt = cprs_pkg::S_DIV_WAIT;
      cprs_pkg::S_DIV_WAIT: if (drsp.done) state_nxt = cprs_pkg::S_ACC;
      cprs_pkg::S_ACC:
        state_nxt = ep_r ? cprs_pkg::S_EDGE_CHK : cprs_pkg::S_COL;
      cprs_pkg::S_CHAIN_END:
        state_nxt = side_r ? cprs_pkg::S_FIN_ROW : cprs_pkg::S_EDGE_CHK;
      cprs_pkg::S_FIN_ROW: state_nxt = cprs_pkg::S_OUT;
      cprs_pkg::S_OUT:
        if (out_chan.ready) state_nxt = olast_r ? cprs_pkg::S_IDLE : cprs_pkg::S_ROW;
      default: state_nxt = cprs_pkg::S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    vcount_nxt = vcount_r;  vovf_nxt = vovf_r;
    ymin_nxt = ymin_r;  ymax_nxt = ymax_r;  low_nxt = low_r;  high_nxt = high_r;
    lcur_nxt = lcur_r;  rcur_nxt = rcur_r;  lend_nxt = lend_r;  rend_nxt = rend_r;
    idx_nxt = idx_r;  fidx_nxt = fidx_r;  found_nxt = found_r;
    side_nxt = side_r;  ep_nxt = ep_r;
    rmin_nxt = rmin_r;  rows_nxt = rows_r;  rowi_nxt = rowi_r;  st_nxt = st_r;
    lo_nxt = lo_r;  hi_nxt = hi_r;
    pxa_nxt = pxa_r;  pya_nxt = pya_r;  pxb_nxt = pxb_r;  pyb_nxt = pyb_r;
    mula_nxt = mula_r;  mulb_nxt = mulb_r;  prod_nxt = prod_r;
    dneg_nxt = dneg_r;  dabs_nxt = dabs_r;
    col_nxt = col_r;  c1_nxt = c1_r;  cmin_nxt = cmin_r;  cmax_nxt = cmax_r;
    any_nxt = any_r;
    orow_nxt = orow_r;  obeg_nxt = obeg_r;  oend_nxt = oend_r;
    olast_nxt = olast_r;  ost_nxt = ost_r;
    unique case (state_r)
      cprs_pkg::S_IDLE: begin
        if (in_acc) begin
          if (vcount_r < CNTW'(MAX_VERTICES)) begin
            vcount_nxt = vcount_r + 1'b1;
            if (vcount_r == '0) begin
              ymin_nxt = in_chan.vertex_y;  ymax_nxt = in_chan.vertex_y;
              low_nxt = '0;  high_nxt = '0;
            end else if (in_chan.vertex_y > ymax_r) begin
              ymax_nxt = in_chan.vertex_y;  high_nxt = IW'(vcount_r);
            end else if (in_chan.vertex_y < ymin_r) begin
              ymin_nxt = in_chan.vertex_y;  low_nxt = IW'(vcount_r);
            end
          end else begin
            vovf_nxt = 1'b1;
          end
        end
      end
      cprs_pkg::S_START: begin
        orow_nxt = '0;  obeg_nxt = '0;  oend_nxt = '0;  olast_nxt = 1'b1;
        priority if (vcount_r < CNTW'(3)) ost_nxt = cprs_pkg::ST_FEW;
        else if (ymax_r <= ymin_r)        ost_nxt = cprs_pkg::ST_FLAT;
        else begin
          rmin_nxt = rmin_c;
          if (rows_full > DW'(MAX_ROWS)) begin
            rows_nxt = ROWW'(MAX_ROWS);  st_nxt = cprs_pkg::ST_OVF;
          end else begin
            rows_nxt = ROWW'(rows_full);
            st_nxt   = vovf_r ? cprs_pkg::ST_OVF : cprs_pkg::ST_OK;
          end
          lend_nxt = high_pv;  rend_nxt = high_r;
          lcur_nxt = low_pv;   rcur_nxt = low_r;
          rowi_nxt = '0;
        end
      end
      cprs_pkg::S_ROW: begin
        lo_nxt = lo_c;  hi_nxt = lo_c + cell_t;
        any_nxt = 1'b0;  side_nxt = 1'b0;  idx_nxt = lcur_r;  found_nxt = 1'b0;
      end
      cprs_pkg::S_EDGE_CHK: ;
      cprs_pkg::S_EDGE_RD: begin
        pxa_nxt = cprs_pkg::rel(rd_xa, origin_x_r);
        pya_nxt = cprs_pkg::rel(rd_ya, origin_y_r);
        pxb_nxt = cprs_pkg::rel(rd_xb, origin_x_r);
        pyb_nxt = cprs_pkg::rel(rd_yb, origin_y_r);
      end
      cprs_pkg::S_EDGE_TEST: begin
        if (mx >= hi_r && !found_r) begin
          found_nxt = 1'b1;  fidx_nxt = idx_r;
        end
        priority if (mn > hi_r) ;
        else if (mx < lo_r) idx_nxt = step_idx;
        else ep_nxt = 1'b0;
      end
      cprs_pkg::S_COL: begin
        col_nxt  = direct_col;
        mula_nxt = dx_c;
        mulb_nxt = dt_c;
        dneg_nxt = d_c < 0;
        dabs_nxt = (d_c < 0) ? DW'(-d_c) : DW'(d_c);
      end
      cprs_pkg::S_MUL:    prod_nxt = mula_r * mulb_r;
      cprs_pkg::S_DIV_GO: ;
      cprs_pkg::S_DIV_WAIT:
        if (drsp.done) col_nxt = div_sum >>> cell_shift_r;
      cprs_pkg::S_ACC: begin
        if (!ep_r) begin
          c1_nxt = col_r;  ep_nxt = 1'b1;
        end else begin
          if (!any_r || lo_cc < cmin_r) cmin_nxt = lo_cc;
          if (!any_r || hi_cc > cmax_r) cmax_nxt = hi_cc;
          any_nxt = 1'b1;
          idx_nxt = step_idx;
        end
      end
      cprs_pkg::S_CHAIN_END: begin
        if (!side_r) begin
          lcur_nxt = found_r ? fidx_r : end_sel;
          side_nxt = 1'b1;  idx_nxt = rcur_r;  found_nxt = 1'b0;
        end else begin
          rcur_nxt = found_r ? fidx_r : end_sel;
        end
      end
      cprs_pkg::S_FIN_ROW: begin
        orow_nxt  = cprs_pkg::sat16(COLW'(row_r_c));
        obeg_nxt  = any_r ? cprs_pkg::sat16(cmin_r) : 16'sd0;
        oend_nxt  = any_r ? 17'(17'(cmax_sat) + 17'sd1) : 17'sd0;
        olast_nxt = ROWW'(rowi_r + 1'b1) == rows_r;
        ost_nxt   = st_r;
      end
      cprs_pkg::S_OUT: begin
        if (out_chan.ready) begin
          if (olast_r) begin
            vcount_nxt = '0;  vovf_nxt = 1'b0;
          end else begin
            rowi_nxt = rowi_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cprs_pkg::S_IDLE;
      origin_x_r   <= '0;
      origin_y_r   <= '0;
      cell_shift_r <= 4'd8;
      vcount_r     <= '0;
      vovf_r       <= 1'b0;
      low_r        <= '0;
      high_r       <= '0;
      lcur_r       <= '0;
      rcur_r       <= '0;
    end else begin
      state_r  <= state_nxt;
      vcount_r <= vcount_nxt;
      vovf_r   <= vovf_nxt;
      low_r    <= low_nxt;
      high_r   <= high_nxt;
      lcur_r   <= lcur_nxt;
      rcur_r   <= rcur_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          cprs_pkg::CFG_ORIGIN_X:   origin_x_r   <= cfg_wdata;
          cprs_pkg::CFG_ORIGIN_Y:   origin_y_r   <= cfg_wdata;
          cprs_pkg::CFG_CELL_SHIFT: cell_shift_r <= cfg_wdata[3:0];
          default: ;
        endcase
      end
    end
    ymin_r <= ymin_nxt;  ymax_r <= ymax_nxt;
    lend_r <= lend_nxt;  rend_r <= rend_nxt;
    idx_r <= idx_nxt;  fidx_r <= fidx_nxt;  found_r <= found_nxt;
    side_r <= side_nxt;  ep_r <= ep_nxt;
    rmin_r <= rmin_nxt;  rows_r <= rows_nxt;  rowi_r <= rowi_nxt;  st_r <= st_nxt;
    lo_r <= lo_nxt;  hi_r <= hi_nxt;
    pxa_r <= pxa_nxt;  pya_r <= pya_nxt;  pxb_r <= pxb_nxt;  pyb_r <= pyb_nxt;
    mula_r <= mula_nxt;  mulb_r <= mulb_nxt;  prod_r <= prod_nxt;
    dneg_r <= dneg_nxt;  dabs_r <= dabs_nxt;
    col_r <= col_nxt;  c1_r <= c1_nxt;  cmin_r <= cmin_nxt;  cmax_r <= cmax_nxt;
    any_r <= any_nxt;
    orow_r <= orow_nxt;  obeg_r <= obeg_nxt;  oend_r <= oend_nxt;
    olast_r <= olast_nxt;  ost_r <= ost_nxt;
  end

  assign out_chan.valid      = state_r == cprs_pkg::S_OUT;
  assign out_chan.row_index  = orow_r;
  assign out_chan.span_begin = obeg_r;
  assign out_chan.span_end   = oend_r;
  assign out_chan.row_last   = olast_r;
  assign out_chan.status     = ost_r;

  a_no_load_during_walk: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_chan.ready && out_chan.valid))
    else $error("vertex load while a span is pending");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vcount_r <= CNTW'(MAX_VERTICES))
    else $error("vertex count beyond store depth");

  a_short_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (out_chan.status == cprs_pkg::ST_FEW ||
                       out_chan.status == cprs_pkg::ST_FLAT) |-> out_chan.row_last)
    else $error("degenerate polygon span not marked last");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> state_r == cprs_pkg::S_DIV_WAIT)
    else $error("divider finished outside its wait state");

endmodule
